// ===== src/gstt_pkg.sv =====
package gstt_pkg;

    localparam int CoordBits = 16;
    localparam int DistBits  = 2 * CoordBits + 2;
    localparam int GateBits  = 16;
    localparam int GateSqBits = 2 * GateBits;
    localparam int CountBits = 8;
    localparam int IdBits    = 16;
    localparam int HitBits   = 16;
    localparam int CoastBits = 9;
    localparam int CfgIdxBits = 2;
    localparam int CfgDataBits = 16;
    localparam int InDataBits = 48;
    localparam int InUserBits = 3;
    localparam int OutDataBits = 96;

    localparam logic [GateBits-1:0]  GateReset    = 16'd500;
    localparam logic [CountBits-1:0] ConfirmReset = 8'd3;
    localparam logic [CountBits-1:0] CoastReset   = 8'd5;
    localparam logic [HitBits-1:0]   HitMax       = 16'hFFFF;
    localparam logic [CoastBits-1:0] CoastMax     = 9'h1FF;

    typedef enum logic [1:0] {
        OP_DETECT    = 2'd0,
        OP_FRAME_END = 2'd1,
        OP_DROP      = 2'd2
    } t_op;

    typedef enum logic [CfgIdxBits-1:0] {
        REG_GATE    = 2'd0,
        REG_CONFIRM = 2'd1,
        REG_COAST   = 2'd2
    } t_reg_idx;

    // tdata layout of a result, highest bit first
    typedef struct packed {
        logic [4:0]                  pad;
        logic                        confirmed;
        logic [HitBits-1:0]          hits;
        logic [CoastBits-1:0]        coast;
        logic signed [CoordBits-1:0] z;
        logic signed [CoordBits-1:0] y;
        logic signed [CoordBits-1:0] x;
        logic [IdBits-1:0]           ident;
        logic                        present;
    } t_result;

endpackage

// ===== src/gated_single_target_tracker_core.sv =====
// Path: a request goes through the input register and then the result register,
// which drives m_axis (one input register, one result register).
// Throughput: one request per cycle; a stalled result holds the next request
// only when that request also ends a frame.
// Reset (i_rst_n low, synchronous): drops the track, clears the candidate and
// the id counter, and restores gate 500, confirm 3, max coast 5.
module gated_single_target_tracker_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // pos_x [15:0], pos_y [31:16], pos_z [47:32]
    input  logic [gstt_pkg::InDataBits-1:0]   s_axis_tdata,
    // operation [1:0], depth_valid [2]
    input  logic [gstt_pkg::InUserBits-1:0]   s_axis_tuser,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // track_present [0], out_track_id [16:1], out_x [32:17], out_y [48:33],
    // out_z [64:49], out_coast [73:65], out_hits [89:74], out_confirmed [90]
    output logic [gstt_pkg::OutDataBits-1:0]  m_axis_tdata,
    input  logic                              i_cfg_wr_en,
    input  logic [gstt_pkg::CfgIdxBits-1:0]   i_cfg_index,
    input  logic [gstt_pkg::CfgDataBits-1:0]  i_cfg_data
);
    import gstt_pkg::*;

    // configuration
    logic [GateBits-1:0]  r_gate;
    logic [CountBits-1:0] r_confirm;
    logic [CountBits-1:0] r_max_coast;

    // input register
    logic                        r_in_valid;
    logic [1:0]                  r_in_op;
    logic                        r_in_dv;
    logic                        r_in_last;
    logic signed [CoordBits-1:0] r_in_x, r_in_y, r_in_z;

    // track and candidate state
    logic                        r_active, n_active;
    logic [IdBits-1:0]           r_ident, n_ident;
    logic signed [CoordBits-1:0] r_px, r_py, r_pz, n_px, n_py, n_pz;
    logic [CoastBits-1:0]        r_coast, n_coast;
    logic [HitBits-1:0]          r_hits, n_hits;
    logic                        r_confirmed, n_confirmed;
    logic [IdBits-1:0]           r_next_id, n_next_id;
    logic                        r_cand_found, n_cand_found;
    logic [DistBits-1:0]         r_cand_dist, n_cand_dist;
    logic signed [CoordBits-1:0] r_cx, r_cy, r_cz, n_cx, n_cy, n_cz;

    // result register
    logic    r_out_valid;
    t_result r_out, n_out;

    t_op                         op;
    logic                        produces;
    logic                        advance;
    logic signed [CoordBits:0]   dx, dy, dz;
    logic signed [DistBits-1:0]  sqx, sqy, sqz;
    logic [DistBits-1:0]         det_dsq;
    logic [GateSqBits-1:0]       gate_sq;
    logic                        take;
    logic                        c_found;
    logic                        c_in_gate;
    logic signed [CoordBits-1:0] c_x, c_y, c_z;
    logic [HitBits-1:0]          hits_inc;
    logic [CoastBits-1:0]        coast_inc;

    assign op       = t_op'(r_in_op);
    assign produces = (op == OP_FRAME_END) || ((op == OP_DETECT) && r_in_last);
    assign advance  = r_in_valid && (!produces || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    assign dx = {r_in_x[CoordBits-1], r_in_x} - {r_px[CoordBits-1], r_px};
    assign dy = {r_in_y[CoordBits-1], r_in_y} - {r_py[CoordBits-1], r_py};
    assign dz = {r_in_z[CoordBits-1], r_in_z} - {r_pz[CoordBits-1], r_pz};
    assign sqx = dx * dx;
    assign sqy = dy * dy;
    assign sqz = dz * dz;
    assign det_dsq = $unsigned(sqx) + $unsigned(sqy) + $unsigned(sqz);
    assign gate_sq = r_gate * r_gate;

    // candidate after this detection
    always_comb begin
        take = 1'b0;
        if ((op == OP_DETECT) && r_in_dv) begin
            if (r_active) begin
                take = !r_cand_found || (det_dsq < r_cand_dist);
            end else begin
                take = !r_cand_found;
            end
        end
        c_found = r_cand_found || take;
        c_x = take ? r_in_x : r_cx;
        c_y = take ? r_in_y : r_cy;
        c_z = take ? r_in_z : r_cz;
        if (take) begin
            c_in_gate = det_dsq <= {2'b00, gate_sq};
        end else begin
            c_in_gate = r_cand_dist <= {2'b00, gate_sq};
        end
    end

    assign hits_inc  = (r_hits == HitMax) ? r_hits : r_hits + 1'b1;
    assign coast_inc = (r_coast == CoastMax) ? r_coast : r_coast + 1'b1;

    always_comb begin
        n_active     = r_active;
        n_ident      = r_ident;
        n_px         = r_px;
        n_py         = r_py;
        n_pz         = r_pz;
        n_coast      = r_coast;
        n_hits       = r_hits;
        n_confirmed  = r_confirmed;
        n_next_id    = r_next_id;
        n_cand_found = r_cand_found;
        n_cand_dist  = r_cand_dist;
        n_cx         = r_cx;
        n_cy         = r_cy;
        n_cz         = r_cz;

        if (op == OP_DROP) begin
            n_active     = 1'b0;
            n_cand_found = 1'b0;
            n_cand_dist  = '1;
            n_cx         = '0;
            n_cy         = '0;
            n_cz         = '0;
        end else if (produces) begin
            if (c_found && (!r_active || c_in_gate)) begin
                if (!r_active) begin
                    n_active    = 1'b1;
                    n_ident     = r_next_id;
                    n_next_id   = r_next_id + 1'b1;
                    n_hits      = HitBits'(1);
                    n_confirmed = r_confirm <= CountBits'(1);
                end else begin
                    n_hits      = hits_inc;
                    n_confirmed = r_confirmed || (hits_inc >= {8'd0, r_confirm});
                end
                n_px    = c_x;
                n_py    = c_y;
                n_pz    = c_z;
                n_coast = '0;
            end else if (r_active) begin
                n_coast = coast_inc;
                if (coast_inc > {1'b0, r_max_coast}) begin
                    n_active = 1'b0;
                end
            end
            n_cand_found = 1'b0;
            n_cand_dist  = '1;
            n_cx         = '0;
            n_cy         = '0;
            n_cz         = '0;
        end else if (take) begin
            n_cand_found = 1'b1;
            n_cand_dist  = r_active ? det_dsq : '0;
            n_cx         = r_in_x;
            n_cy         = r_in_y;
            n_cz         = r_in_z;
        end
    end

    always_comb begin
        n_out = '0;
        if (n_active) begin
            n_out.present   = 1'b1;
            n_out.ident     = n_ident;
            n_out.x         = n_px;
            n_out.y         = n_py;
            n_out.z         = n_pz;
            n_out.coast     = n_coast;
            n_out.hits      = n_hits;
            n_out.confirmed = n_confirmed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate      <= GateReset;
            r_confirm   <= ConfirmReset;
            r_max_coast <= CoastReset;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_GATE:    r_gate      <= i_cfg_data;
                REG_CONFIRM: r_confirm   <= i_cfg_data[CountBits-1:0];
                REG_COAST:   r_max_coast <= i_cfg_data[CountBits-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_op   <= s_axis_tuser[1:0];
            r_in_dv   <= s_axis_tuser[2];
            r_in_last <= s_axis_tlast;
            r_in_x    <= s_axis_tdata[CoordBits-1:0];
            r_in_y    <= s_axis_tdata[2*CoordBits-1:CoordBits];
            r_in_z    <= s_axis_tdata[3*CoordBits-1:2*CoordBits];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_ident      <= '0;
            r_px         <= '0;
            r_py         <= '0;
            r_pz         <= '0;
            r_coast      <= '0;
            r_hits       <= '0;
            r_confirmed  <= 1'b0;
            r_next_id    <= '0;
            r_cand_found <= 1'b0;
            r_cand_dist  <= '1;
            r_cx         <= '0;
            r_cy         <= '0;
            r_cz         <= '0;
        end else if (advance) begin
            r_active     <= n_active;
            r_ident      <= n_ident;
            r_px         <= n_px;
            r_py         <= n_py;
            r_pz         <= n_pz;
            r_coast      <= n_coast;
            r_hits       <= n_hits;
            r_confirmed  <= n_confirmed;
            r_next_id    <= n_next_id;
            r_cand_found <= n_cand_found;
            r_cand_dist  <= n_cand_dist;
            r_cx         <= n_cx;
            r_cy         <= n_cy;
            r_cz         <= n_cz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && produces) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && produces) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== src/gstt_checker.sv =====
module gstt_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [gstt_pkg::OutDataBits-1:0]  m_axis_tdata
);
    import gstt_pkg::*;

    t_result res;
    assign res = m_axis_tdata;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // no track: every field reads zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !res.present |-> m_axis_tdata == '0)
        else $error("fields set without a track");

    // a live track has at least one hit
    a_hits_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.present |-> res.hits != '0)
        else $error("track with zero hits");

    // a live track never coasts past 256 frames
    a_coast_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.present |-> res.coast <= CoastBits'(256))
        else $error("coast count out of range");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind gated_single_target_tracker_core gstt_checker u_gstt_checker (.*);
